// File: src/trcf_pkg.sv
`timescale 1ns / 1ps
package trcf_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int POS_W       = 32;
  localparam int FIELD_W     = 32;
  localparam int CFG_W       = 31;
  localparam int CUR_W       = 28;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TOROID_RADIUS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZONTAL_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COIL_THICKNESS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COIL_CURRENT      = 3'd5;

  localparam logic [CFG_W-1:0] THICKNESS_RESET = 31'd65536;

  localparam int GW    = 37;
  localparam int RHO_W = 33;
  localparam int CRN_W = 34;

  localparam logic [1:0] KIND_ZERO   = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_RAMP   = 2'd2;
  localparam logic [1:0] KIND_CORNER = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } query_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
  } field_t;

  typedef struct packed {
    logic [POS_W-1:0]   ax;
    logic [POS_W-1:0]   ay;
    logic [POS_W:0]     az;
    logic [2*POS_W-1:0] s;
    logic               xneg;
    logic               yneg;
  } pt_t;

  typedef struct packed {
    logic [POS_W-1:0]    ax;
    logic [POS_W-1:0]    ay;
    logic [2*POS_W-1:0]  s;
    logic                xneg;
    logic                yneg;
    logic [1:0]          kind;
    logic signed [GW-1:0] num;
  } cls_t;

endpackage

// File: src/trcf_stream_if.sv
`timescale 1ns / 1ps
interface trcf_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/trcf_isqrt.sv
`timescale 1ns / 1ps
module trcf_isqrt #(
  parameter int RW = trcf_pkg::RHO_W,
  parameter int VW = 2 * trcf_pkg::RHO_W,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [VW-1:0] rad,
  input  logic [PW-1:0] pay_in,
  output logic          out_v,
  output logic [RW-1:0] root,
  output logic [PW-1:0] pay_out
);
  localparam int W = 2 * RW + 2;

  logic          v_q    [RW];
  logic [W-1:0]  rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [PW-1:0] pay_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic          v_in;
    logic [W-1:0]  rem_in;
    logic [W-1:0]  t;
    logic [RW-1:0] root_in;
    logic [RW-1:0] root_next;
    logic [PW-1:0] pay_k;
    logic          hit;

    if (k == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = W'(rad);
      assign root_in = '0;
      assign pay_k   = pay_in;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign pay_k   = pay_q[k-1];
    end

    assign t   = (W'(root_in) << (B + 1)) + (W'(1) << (2 * B));
    assign hit = rem_in >= t;

    always_comb begin
      root_next = root_in;
      if (hit) begin
        root_next[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= hit ? rem_in - t : rem_in;
        root_q[k] <= root_next;
        pay_q[k]  <= pay_k;
      end
    end
  end

  assign out_v   = v_q[RW-1];
  assign root    = root_q[RW-1];
  assign pay_out = pay_q[RW-1];
endmodule

// File: src/toroid_rectangular_coil_field_core.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; every square root and divider bit has its own
// pipeline stage, so the rate is set by the single global stall of the pipeline.
// A two-entry output stage (result register plus skid) stalls the pipeline only when full.
// Reset (rst, synchronous): clears all valid bits and loads the register defaults.
module toroid_rectangular_coil_field_core #(
  parameter int COORD_WIDTH = trcf_pkg::COORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [trcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trcf_pkg::CFG_W-1:0]       cfg_data,
  trcf_stream_if.sink                      query,
  trcf_stream_if.source                    result
);
  localparam int PW  = trcf_pkg::POS_W;
  localparam int CW  = (COORD_WIDTH > PW) ? PW : COORD_WIDTH;
  localparam int SH  = PW - CW;
  localparam int GW  = trcf_pkg::GW;
  localparam int RHW = trcf_pkg::RHO_W;
  localparam int CNW = trcf_pkg::CRN_W;
  localparam int QB  = 33;
  localparam int NW  = 128;
  localparam int DW  = 107;
  localparam int RMW = 140;
  localparam int SCALE_SHIFT = 37;
  localparam logic [9:0]  DEN_SCALE = 10'd625;
  localparam logic [QB:0] LIM_POS   = (QB + 1)'(32'h7FFF_FFFF);
  localparam logic [QB:0] LIM_NEG   = (QB + 1)'(32'h8000_0000);

  typedef struct packed {
    logic [RMW-1:0] rem_x;
    logic [RMW-1:0] rem_y;
    logic [QB-1:0]  q_x;
    logic [QB-1:0]  q_y;
    logic           ovf_x;
    logic           ovf_y;
    logic [DW-1:0]  dd;
    logic           neg_x;
    logic           neg_y;
    logic           zero;
  } dv_t;

  // configuration
  logic [trcf_pkg::CFG_W-1:0]        toroid_radius;
  logic [trcf_pkg::CFG_W-1:0]        horizontal_length;
  logic [trcf_pkg::CFG_W-1:0]        vertical_length;
  logic [trcf_pkg::CFG_W-1:0]        corner_radius;
  logic [trcf_pkg::CFG_W-1:0]        coil_thickness;
  logic signed [trcf_pkg::CUR_W-1:0] coil_current;

  always_ff @(posedge clk) begin
    if (rst) begin
      toroid_radius     <= '0;
      horizontal_length <= '0;
      vertical_length   <= '0;
      corner_radius     <= '0;
      coil_thickness    <= trcf_pkg::THICKNESS_RESET;
      coil_current      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trcf_pkg::CFG_TOROID_RADIUS:     toroid_radius     <= cfg_data;
        trcf_pkg::CFG_HORIZONTAL_LENGTH: horizontal_length <= cfg_data;
        trcf_pkg::CFG_VERTICAL_LENGTH:   vertical_length   <= cfg_data;
        trcf_pkg::CFG_CORNER_RADIUS:     corner_radius     <= cfg_data;
        trcf_pkg::CFG_COIL_THICKNESS:    coil_thickness    <= cfg_data;
        trcf_pkg::CFG_COIL_CURRENT:      coil_current      <= cfg_data[trcf_pkg::CUR_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry in half units
  logic signed [GW-1:0] geo_r2, geo_hl, geo_cr2, geo_d, geo_z1, geo_z2;
  logic signed [GW-1:0] geo_rmin1, geo_rmin2, geo_rmax1, geo_rmax2;
  logic [trcf_pkg::CUR_W-1:0] cur_mag;
  logic                       cur_neg;

  assign geo_r2    = GW'({toroid_radius, 1'b0});
  assign geo_hl    = GW'(horizontal_length);
  assign geo_cr2   = GW'({corner_radius, 1'b0});
  assign geo_d     = GW'({coil_thickness, 1'b0});
  assign geo_z1    = GW'(vertical_length);
  assign geo_z2    = geo_z1 + geo_cr2;
  assign geo_rmin1 = geo_r2 - geo_hl;
  assign geo_rmin2 = geo_rmin1 - geo_cr2;
  assign geo_rmax1 = geo_r2 + geo_hl;
  assign geo_rmax2 = geo_rmax1 + geo_cr2;
  assign cur_neg   = coil_current[trcf_pkg::CUR_W-1];
  assign cur_mag   = cur_neg ? trcf_pkg::CUR_W'(-coil_current)
                             : trcf_pkg::CUR_W'(coil_current);

  // stall control
  logic             en;
  logic             skid_v;
  logic             res_v;
  trcf_pkg::field_t skid_q;
  trcf_pkg::field_t res_q;

  assign en          = ~skid_v;
  assign query.ready = en;

  // stage A: sign extend, magnitudes
  logic signed [PW-1:0] xs, ys, zs;
  logic                 a_v;
  logic [PW-1:0]        a_ax, a_ay;
  logic [PW:0]          a_az;
  logic                 a_xneg, a_yneg;

  assign xs = $signed(query.data.pos_x << SH) >>> SH;
  assign ys = $signed(query.data.pos_y << SH) >>> SH;
  assign zs = $signed(query.data.pos_z << SH) >>> SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ax   <= xs[PW-1] ? PW'(-xs) : PW'(xs);
      a_ay   <= ys[PW-1] ? PW'(-ys) : PW'(ys);
      a_az   <= {(zs[PW-1] ? PW'(-zs) : PW'(zs)), 1'b0};
      a_xneg <= xs[PW-1];
      a_yneg <= ys[PW-1];
    end
  end

  // stage B: squares
  logic            b_v;
  logic [2*PW-1:0] b_sqx, b_sqy;
  logic [PW-1:0]   b_ax, b_ay;
  logic [PW:0]     b_az;
  logic            b_xneg, b_yneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sqx  <= a_ax * a_ax;
      b_sqy  <= a_ay * a_ay;
      b_ax   <= a_ax;
      b_ay   <= a_ay;
      b_az   <= a_az;
      b_xneg <= a_xneg;
      b_yneg <= a_yneg;
    end
  end

  // stage C: sum of squares
  logic          c_v;
  trcf_pkg::pt_t c_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_p.ax   <= b_ax;
      c_p.ay   <= b_ay;
      c_p.az   <= b_az;
      c_p.s    <= b_sqx + b_sqy;
      c_p.xneg <= b_xneg;
      c_p.yneg <= b_yneg;
    end
  end

  // radius
  logic                               r1_v;
  logic [RHW-1:0]                     r1_root;
  logic [$bits(trcf_pkg::pt_t)-1:0]   r1_pay;
  trcf_pkg::pt_t                      r1_p;

  trcf_isqrt #(
    .RW (RHW),
    .VW (2 * PW + 2),
    .PW ($bits(trcf_pkg::pt_t))
  ) u_rho (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (c_v),
    .rad     ({c_p.s, 2'b00}),
    .pay_in  (c_p),
    .out_v   (r1_v),
    .root    (r1_root),
    .pay_out (r1_pay)
  );

  assign r1_p = trcf_pkg::pt_t'(r1_pay);

  // stage D: classify
  logic signed [GW-1:0] rho, azs, cls_num;
  logic [1:0]           cls_kind;
  logic                 inr, inz;
  logic signed [GW-1:0] dz_full, dr_full;

  assign rho     = GW'(r1_root);
  assign azs     = GW'(r1_p.az);
  assign inr     = (rho >= geo_rmin1) && (rho <= geo_rmax1);
  assign inz     = azs < geo_z1;
  assign dz_full = azs - geo_z1;
  assign dr_full = (rho <= geo_rmin1) ? geo_rmin1 - rho : rho - geo_rmax1;

  always_comb begin
    cls_kind = trcf_pkg::KIND_FULL;
    cls_num  = '0;
    if (r1_p.s == '0 || azs >= geo_z2 || rho <= geo_rmin2 || rho >= geo_rmax2) begin
      cls_kind = trcf_pkg::KIND_ZERO;
    end else if (inz && inr) begin
      cls_kind = trcf_pkg::KIND_FULL;
    end else if (inz) begin
      if (rho <= geo_rmin2 + geo_d) begin
        cls_kind = trcf_pkg::KIND_RAMP;
        cls_num  = rho - geo_rmin2;
      end else if (rho >= geo_rmax2 - geo_d) begin
        cls_kind = trcf_pkg::KIND_RAMP;
        cls_num  = geo_rmax2 - rho;
      end
    end else if (inr) begin
      if (azs >= geo_z2 - geo_d) begin
        cls_kind = trcf_pkg::KIND_RAMP;
        cls_num  = geo_z2 - azs;
      end
    end else begin
      cls_kind = trcf_pkg::KIND_CORNER;
    end
  end

  logic           d_v;
  trcf_pkg::cls_t d_p;
  logic [RHW-1:0] d_dz, d_dr;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_p.ax   <= r1_p.ax;
      d_p.ay   <= r1_p.ay;
      d_p.s    <= r1_p.s;
      d_p.xneg <= r1_p.xneg;
      d_p.yneg <= r1_p.yneg;
      d_p.kind <= cls_kind;
      d_p.num  <= cls_num;
      d_dz     <= RHW'(dz_full);
      d_dr     <= RHW'(dr_full);
    end
  end

  // stage E: corner squares
  logic             e_v;
  trcf_pkg::cls_t   e_p;
  logic [2*RHW-1:0] e_dz2, e_dr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_p   <= d_p;
      e_dz2 <= d_dz * d_dz;
      e_dr2 <= d_dr * d_dr;
    end
  end

  // stage F: corner radicand
  logic           f_v;
  trcf_pkg::cls_t f_p;
  logic [2*RHW:0] f_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_p   <= e_p;
      f_sum <= (2 * RHW + 1)'(e_dz2) + (2 * RHW + 1)'(e_dr2);
    end
  end

  // corner distance
  logic                              r2_v;
  logic [CNW-1:0]                    r2_root;
  logic [$bits(trcf_pkg::cls_t)-1:0] r2_pay;
  trcf_pkg::cls_t                    r2_p;

  trcf_isqrt #(
    .RW (CNW),
    .VW (2 * RHW + 1),
    .PW ($bits(trcf_pkg::cls_t))
  ) u_corner (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (f_v),
    .rad     (f_sum),
    .pay_in  (f_p),
    .out_v   (r2_v),
    .root    (r2_root),
    .pay_out (r2_pay)
  );

  assign r2_p = trcf_pkg::cls_t'(r2_pay);

  // stage G: enclosed fraction
  logic signed [GW-1:0] dr, fin_num;
  logic [1:0]           fin_kind;
  logic                 fin_zero;

  assign dr = GW'(r2_root);

  always_comb begin
    fin_kind = r2_p.kind;
    fin_num  = r2_p.num;
    if (r2_p.kind == trcf_pkg::KIND_CORNER) begin
      if (dr < geo_cr2 - geo_d) begin
        fin_kind = trcf_pkg::KIND_FULL;
      end else if (dr < geo_cr2) begin
        fin_kind = trcf_pkg::KIND_RAMP;
        fin_num  = geo_cr2 - dr;
      end else begin
        fin_kind = trcf_pkg::KIND_ZERO;
      end
    end
  end

  assign fin_zero = (fin_kind == trcf_pkg::KIND_ZERO) ||
                    ((fin_kind == trcf_pkg::KIND_RAMP) && (fin_num <= 0 || geo_d == 0));

  logic            g_v;
  logic [RHW-1:0]  g_num, g_den;
  logic            g_zero, g_negx, g_negy;
  logic [PW-1:0]   g_ax, g_ay;
  logic [2*PW-1:0] g_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= r2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_num  <= (fin_kind == trcf_pkg::KIND_RAMP) ? RHW'(fin_num) : RHW'(1);
      g_den  <= (fin_kind == trcf_pkg::KIND_RAMP) ? RHW'(geo_d) : RHW'(1);
      g_zero <= fin_zero;
      g_negx <= cur_neg ^ r2_p.yneg;
      g_negy <= ~(cur_neg ^ r2_p.xneg);
      g_ax   <= r2_p.ax;
      g_ay   <= r2_p.ay;
      g_s    <= r2_p.s;
    end
  end

  // stage H: scaled current and denominator factor
  logic                               h_v;
  logic [trcf_pkg::CUR_W+RHW-1:0]     h_inum;
  logic [RHW+9:0]                     h_den;
  logic                               h_zero, h_negx, h_negy;
  logic [PW-1:0]                      h_ax, h_ay;
  logic [2*PW-1:0]                    h_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (en) begin
      h_v <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_inum <= cur_mag * g_num;
      h_den  <= g_den * DEN_SCALE;
      h_zero <= g_zero;
      h_negx <= g_negx;
      h_negy <= g_negy;
      h_ax   <= g_ax;
      h_ay   <= g_ay;
      h_s    <= g_s;
    end
  end

  // stage I: partial products
  logic        i_v;
  logic [62:0] i_nx_lo, i_ny_lo;
  logic [61:0] i_nx_hi, i_ny_hi;
  logic [53:0] i_d_ll, i_d_lh;
  logic [52:0] i_d_hl, i_d_hh;
  logic        i_zero, i_negx, i_negy;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (en) begin
      i_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_nx_lo <= h_inum[30:0] * h_ay;
      i_nx_hi <= h_inum[60:31] * h_ay;
      i_ny_lo <= h_inum[30:0] * h_ax;
      i_ny_hi <= h_inum[60:31] * h_ax;
      i_d_ll  <= h_den[21:0] * h_s[31:0];
      i_d_lh  <= h_den[21:0] * h_s[63:32];
      i_d_hl  <= h_den[42:22] * h_s[31:0];
      i_d_hh  <= h_den[42:22] * h_s[63:32];
      i_zero  <= h_zero;
      i_negx  <= h_negx;
      i_negy  <= h_negy;
    end
  end

  // stage J: dividends and divisor
  logic          j_v;
  logic [NW-1:0] j_nx, j_ny;
  logic [DW-1:0] j_d;
  logic          j_zero, j_negx, j_negy;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_v <= 1'b0;
    end else if (en) begin
      j_v <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_nx   <= ((NW'(i_nx_hi) << 31) + NW'(i_nx_lo)) << SCALE_SHIFT;
      j_ny   <= ((NW'(i_ny_hi) << 31) + NW'(i_ny_lo)) << SCALE_SHIFT;
      j_d    <= DW'(i_d_ll) + (DW'(i_d_lh) << 32) + (DW'(i_d_hl) << 22) +
                (DW'(i_d_hh) << 54);
      j_zero <= i_zero;
      j_negx <= i_negx;
      j_negy <= i_negy;
    end
  end

  // stage K and divider: one quotient bit per stage
  logic dv_v [QB+1];
  dv_t  dv_q [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= j_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_q[0].rem_x <= RMW'(j_nx);
      dv_q[0].rem_y <= RMW'(j_ny);
      dv_q[0].q_x   <= '0;
      dv_q[0].q_y   <= '0;
      dv_q[0].ovf_x <= RMW'(j_nx) >= (RMW'(j_d) << QB);
      dv_q[0].ovf_y <= RMW'(j_ny) >= (RMW'(j_d) << QB);
      dv_q[0].dd    <= j_d;
      dv_q[0].neg_x <= j_negx;
      dv_q[0].neg_y <= j_negy;
      dv_q[0].zero  <= j_zero;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [RMW-1:0] t;
    dv_t            nxt;

    assign t = RMW'(dv_q[k].dd) << B;

    always_comb begin
      nxt = dv_q[k];
      if (dv_q[k].rem_x >= t) begin
        nxt.rem_x  = dv_q[k].rem_x - t;
        nxt.q_x[B] = 1'b1;
      end
      if (dv_q[k].rem_y >= t) begin
        nxt.rem_y  = dv_q[k].rem_y - t;
        nxt.q_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[k+1] <= nxt;
      end
    end
  end

  // stage R: round, saturate, sign
  dv_t                      dvo;
  logic                     rnd_x, rnd_y;
  logic [QB:0]              qr_x, qr_y, lim_x, lim_y;
  logic [PW-1:0]            mag_x, mag_y;
  trcf_pkg::field_t         fin_word;

  assign dvo   = dv_q[QB];
  assign rnd_x = (dvo.rem_x << 1) >= RMW'(dvo.dd);
  assign rnd_y = (dvo.rem_y << 1) >= RMW'(dvo.dd);
  assign qr_x  = {1'b0, dvo.q_x} + (QB + 1)'(rnd_x);
  assign qr_y  = {1'b0, dvo.q_y} + (QB + 1)'(rnd_y);
  assign lim_x = dvo.neg_x ? LIM_NEG : LIM_POS;
  assign lim_y = dvo.neg_y ? LIM_NEG : LIM_POS;
  assign mag_x = (dvo.ovf_x || qr_x > lim_x) ? PW'(lim_x) : PW'(qr_x);
  assign mag_y = (dvo.ovf_y || qr_y > lim_y) ? PW'(lim_y) : PW'(qr_y);

  always_comb begin
    fin_word.field_x = dvo.neg_x ? -$signed(mag_x) : $signed(mag_x);
    fin_word.field_y = dvo.neg_y ? -$signed(mag_y) : $signed(mag_y);
    if (dvo.zero) begin
      fin_word = '0;
    end
  end

  logic             r_v;
  trcf_pkg::field_t r_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (en) begin
      r_v <= dv_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_q <= fin_word;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (result.ready) begin
        skid_v <= 1'b0;
      end
    end else if (r_v) begin
      if (!res_v || result.ready) begin
        res_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (result.ready) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (result.ready) begin
        res_q <= skid_q;
      end
    end else if (r_v) begin
      if (!res_v || result.ready) begin
        res_q <= r_q;
      end else begin
        skid_q <= r_q;
      end
    end
  end

  assign result.valid = res_v;
  assign result.data  = res_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> res_v)
    else $error("skid holds a word while the result register is empty");
  a_blocked_push: assert property (@(posedge clk) disable iff (rst)
    !skid_v && r_v && res_v && !result.ready |=> skid_v)
    else $error("word pushed into a blocked result register was not kept in skid");
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_v && result.ready |=> !skid_v && res_v)
    else $error("skid did not drain into the result register");
`endif
endmodule

// File: sim/trcf_field_checker.sv
`timescale 1ns / 1ps
module trcf_field_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [trcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trcf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           q_valid,
  input  logic                           q_ready,
  input  trcf_pkg::query_t               q_data,
  input  logic                           r_valid,
  input  logic                           r_ready,
  input  trcf_pkg::field_t               r_data,
  output int                             fail_count,
  output int                             pending
);
  logic [trcf_pkg::CFG_W-1:0] tor_radius, horiz_len, vert_len, crn_radius, thickness;
  longint                     current;
  trcf_pkg::field_t           expected_fields[$];

  function automatic logic [63:0] int_sqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [127:0] c;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      c = {64'd0, r | (64'd1 << b)};
      if (c * c <= v) r = c[63:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] field_part(logic [63:0] inum, logic [63:0] mag, bit neg,
                                             logic [63:0] den, logic [63:0] s);
    logic [127:0] n, d, q, r, lim;
    logic [63:0]  dscale;
    n = ({64'd0, inum} * {64'd0, mag}) << 37;
    dscale = 64'd625 * den;
    d = {64'd0, dscale} * {64'd0, s};
    if (d == 0) return 32'd0;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic trcf_pkg::field_t coil_field(trcf_pkg::query_t q);
    trcf_pkg::field_t f;
    longint      x, y, z, rho, az, z1, z2, rmin1, rmin2, rmax1, rmax2, cr2, d, num, den, dr;
    logic [63:0] ax, ay, s, dz, dr2, inum, icur;
    bit          enclosed, ineg;
    x = q.pos_x;
    y = q.pos_y;
    z = q.pos_z;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    s = ax * ax + ay * ay;
    f.field_x = 0;
    f.field_y = 0;
    if (s == 0) return f;
    rho = int_sqrt({62'd0, s, 2'b00});
    az = 2 * (z < 0 ? -z : z);
    cr2 = 2 * longint'(crn_radius);
    d = 2 * longint'(thickness);
    z1 = vert_len;
    z2 = z1 + cr2;
    rmin1 = 2 * longint'(tor_radius) - longint'(horiz_len);
    rmin2 = rmin1 - cr2;
    rmax1 = 2 * longint'(tor_radius) + longint'(horiz_len);
    rmax2 = rmax1 + cr2;
    num = 1;
    den = 1;
    enclosed = 1;
    if (az >= z2 || rho <= rmin2 || rho >= rmax2) return f;
    if (az < z1 && rho >= rmin1 && rho <= rmax1) begin
    end else if (az < z1) begin
      if (rho <= rmin2 + d) begin
        num = rho - rmin2;
        den = d;
      end else if (rho >= rmax2 - d) begin
        num = rmax2 - rho;
        den = d;
      end
    end else if (rho >= rmin1 && rho <= rmax1) begin
      if (az >= z2 - d) begin
        num = z2 - az;
        den = d;
      end
    end else begin
      dz = az - z1;
      dr2 = rho <= rmin1 ? rmin1 - rho : rho - rmax1;
      dr = int_sqrt({64'd0, dz} * {64'd0, dz} + {64'd0, dr2} * {64'd0, dr2});
      if (dr < cr2 - d) begin
      end else if (dr < cr2) begin
        num = cr2 - dr;
        den = d;
      end else begin
        enclosed = 0;
      end
    end
    if (!enclosed || num <= 0 || den <= 0) return f;
    ineg = current < 0;
    icur = ineg ? -current : current;
    inum = icur * num;
    f.field_x = field_part(inum, ay, ineg != (y < 0), den, s);
    f.field_y = field_part(inum, ax, (ineg == (x < 0)) && x != 0, den, s);
    return f;
  endfunction

  always @(posedge clk) begin
    trcf_pkg::field_t want;
    if (rst) begin
      tor_radius = 0;
      horiz_len = 0;
      vert_len = 0;
      crn_radius = 0;
      thickness = trcf_pkg::THICKNESS_RESET;
      current = 0;
      expected_fields.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          trcf_pkg::CFG_TOROID_RADIUS:     tor_radius = cfg_data;
          trcf_pkg::CFG_HORIZONTAL_LENGTH: horiz_len = cfg_data;
          trcf_pkg::CFG_VERTICAL_LENGTH:   vert_len = cfg_data;
          trcf_pkg::CFG_CORNER_RADIUS:     crn_radius = cfg_data;
          trcf_pkg::CFG_COIL_THICKNESS:    thickness = cfg_data;
          trcf_pkg::CFG_COIL_CURRENT:
            current = longint'(signed'(cfg_data[trcf_pkg::CUR_W-1:0]));
          default: ;
        endcase
      end
      if (q_valid && q_ready) expected_fields.push_back(coil_field(q_data));
      if (r_valid && r_ready) begin
        if (expected_fields.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word field_x=%0d field_y=%0d", $time,
                   r_data.field_x, r_data.field_y);
        end else begin
          want = expected_fields.pop_front();
          if (r_data.field_x !== want.field_x) begin
            fail_count++;
            $display("%0t: field_x expected %0d actual %0d", $time, want.field_x,
                     r_data.field_x);
          end
          if (r_data.field_y !== want.field_y) begin
            fail_count++;
            $display("%0t: field_y expected %0d actual %0d", $time, want.field_y,
                     r_data.field_y);
          end
        end
      end
      pending = expected_fields.size();
    end
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end
endmodule

// File: sim/tb_toroid_rectangular_coil_field_core.sv
`timescale 1ns / 1ps
module tb_toroid_rectangular_coil_field_core;
  localparam int MM = 65536;
  localparam int DRAIN = 130;
  localparam int STALL_LIMIT = 8000;
  localparam int HOLD_CYCLES = 1800;

  logic                           clk, rst, cfg_we;
  logic [trcf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [trcf_pkg::CFG_W-1:0]     cfg_data;
  int                             fail_count, pending, idle_cycles, words_out;
  bit                             squeeze;
  longint                         g_r, g_hl, g_vl, g_cr, g_dc;

  trcf_stream_if #(.word_t(trcf_pkg::query_t)) query_ch ();
  trcf_stream_if #(.word_t(trcf_pkg::field_t)) result_ch ();

  toroid_rectangular_coil_field_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .query(query_ch), .result(result_ch)
  );

  trcf_field_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(query_ch.valid), .q_ready(query_ch.ready), .q_data(query_ch.data),
    .r_valid(result_ch.valid), .r_ready(result_ch.ready), .r_data(result_ch.data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (query_ch.valid && query_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    int gap;
    bit held;
    held = 0;
    words_out = 0;
    result_ch.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ((words_out / 64) % 3 == 0) ? 0 : $urandom_range(0, 17);
      if (squeeze && !held) begin
        held = 1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        result_ch.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready <= 1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      words_out++;
      @(negedge clk);
    end
  end

  task automatic send(longint x, longint y, longint z);
    int gap;
    gap = ((words_out / 50) % 4 == 1) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      query_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    query_ch.data <= '{pos_x: x[31:0], pos_y: y[31:0], pos_z: z[31:0]};
    query_ch.valid <= 1;
    do @(posedge clk); while (!(query_ch.valid && query_ch.ready));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [trcf_pkg::CFG_IDX_W-1:0] idx, longint value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value[trcf_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    query_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic setup(longint r, longint hl, longint vl, longint cr, longint dc, longint cur);
    drain();
    g_r = r;
    g_hl = hl;
    g_vl = vl;
    g_cr = cr;
    g_dc = dc;
    write_reg(trcf_pkg::CFG_TOROID_RADIUS, r);
    write_reg(trcf_pkg::CFG_HORIZONTAL_LENGTH, hl);
    write_reg(trcf_pkg::CFG_VERTICAL_LENGTH, vl);
    write_reg(trcf_pkg::CFG_CORNER_RADIUS, cr);
    write_reg(trcf_pkg::CFG_COIL_THICKNESS, dc);
    write_reg(trcf_pkg::CFG_COIL_CURRENT, cur);
  endtask

  function automatic longint spread(longint e);
    longint v;
    if (e > 64'h7FFF_FFFF) e = 64'h7FFF_FFFF;
    v = $urandom_range(0, int'(e));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic send_random(int count);
    longint x, y, z, ext, extz, t;
    int     mode;
    repeat (count) begin
      mode = $urandom_range(0, 9);
      ext = g_r + g_hl / 2 + g_cr + g_dc;
      extz = g_vl / 2 + g_cr + g_dc;
      if (mode < 7) begin
        x = spread(ext);
        y = spread(ext / 4);
        z = spread(extz);
        if ($urandom_range(0, 1)) begin
          t = x;
          x = y;
          y = t;
        end
      end else if (mode < 9) begin
        x = int'($urandom);
        y = int'($urandom);
        z = int'($urandom);
      end else begin
        x = spread(4096);
        y = spread(4096);
        z = spread(4096);
      end
      send(x, y, z);
    end
  endtask

  initial begin
    longint r, hl, vl, cr, dc;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    squeeze = 0;
    idle_cycles = 0;
    query_ch.valid = 0;
    query_ch.data = '0;
    g_r = 0;
    g_hl = 0;
    g_vl = 0;
    g_cr = 0;
    g_dc = MM;
    repeat (10) @(negedge clk);
    rst = 0;
    send_random(20);

    r = 100 * MM;
    hl = 20 * MM;
    vl = 30 * MM;
    cr = 5 * MM;
    dc = 2 * MM;
    setup(r, hl, vl, cr, dc, 1000);
    send(0, 0, 0);
    send(0, 0, 32'h7FFF_FFFF);
    send(r, 0, 0);
    send(-r, 0, 0);
    send(0, r, 0);
    send(0, -r, -MM);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
    send(-64'sd2147483648, 0, 0);
    send(0, -64'sd2147483648, -64'sd2147483648);
    send(r - hl / 2 - cr - dc / 2, 0, 0);
    send(r + hl / 2 + cr - dc / 2, 0, 0);
    send(-r, 0, vl / 2 + cr - dc / 2);
    send(0, r + hl / 2 + cr * 7 / 10, vl / 2 + cr * 7 / 10);
    send(r + hl / 2 + cr * 6 / 10, 0, -(vl / 2 + cr * 6 / 10));
    send(r - hl / 2 - cr * 72 / 100, 0, vl / 2 + cr * 72 / 100);
    send(r + hl / 2 + cr * 9 / 10, 0, vl / 2 + cr * 9 / 10);
    send(3 * r, 0, 0);
    send(r / 2, r / 2, 0);
    send(1, 0, 0);
    send_random(140);

    setup(r, hl, vl, 0, 1, -134217728);
    send(r - hl / 2, 0, 0);
    send(r, 0, vl / 2);
    send_random(60);

    setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          134217727);
    send_random(60);

    setup(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 134217727);
    send(1, 0, 0);
    send(0, -1, 0);
    send_random(60);

    setup(80 * MM, 10 * MM, 20 * MM, 10 * MM, 8 * MM, -5000);
    squeeze = 1;
    send_random(150);

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: toroid_rectangular_coil_field_core.f
src/trcf_pkg.sv
src/trcf_stream_if.sv
src/trcf_isqrt.sv
src/toroid_rectangular_coil_field_core.sv
sim/trcf_field_checker.sv
sim/tb_toroid_rectangular_coil_field_core.sv
